@@ rtl/irdac_pkg.sv @@
// Shared types and constants for the IR docking alignment controller.
// No dependencies.
`timescale 1ns / 1ps
package irdac_pkg;

  localparam int unsigned NO_DATA_TICKS = 7;
  localparam logic signed [17:0] CENTRE_LIMIT = 18'sd327;
  localparam logic [17:0] UNIT_OFFSET = 18'd32768;

  typedef enum logic [1:0] {
    OP_OFFSET = 2'd0,
    OP_TICK   = 2'd1,
    OP_YAW    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CH_NONE  = 2'd0,
    CH_DRIVE = 2'd1,
    CH_DOCK  = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    M_UNFIX  = 2'd0,
    M_FIXING = 2'd1,
    M_ROTATE = 2'd2,
    M_FIXED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_FIX_MOVE_SPEED   = 3'd0,
    CFG_FIX_ROTATE_SPEED = 3'd1,
    CFG_HIGH_SPEED       = 3'd2,
    CFG_LOW_SPEED        = 3'd3,
    CFG_CENTER_SPEED     = 3'd4,
    CFG_INV_WHEEL_SPACING = 3'd5,
    CFG_SWING_ANGLE      = 3'd6,
    CFG_FIX_MOVE_TICKS   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
    logic sel;
  } dp_cmd_t;

  typedef struct packed {
    logic two;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0]         channel;
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
  } res_t;

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    neg_sat16 = (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

endpackage

@@ rtl/irdac_if.sv @@
// Valid/ready channel interfaces for input events and result transactions.
// No dependencies.
`timescale 1ns / 1ps
interface irdac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [17:0] ir_value;
  logic [15:0]        yaw_angle;
  modport source (output valid, op, ir_value, yaw_angle, input ready);
  modport sink (input valid, op, ir_value, yaw_angle, output ready);
endinterface

interface irdac_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic signed [15:0] lin_vel;
  logic signed [15:0] ang_vel;
  logic [1:0]         mode;
  logic               failed;
  logic               last;
  modport source (output valid, channel, lin_vel, ang_vel, mode, failed, last, input ready);
  modport sink (input valid, channel, lin_vel, ang_vel, mode, failed, last, output ready);
endinterface

@@ rtl/ir_dock_alignment_controller.sv @@
// IR docking alignment controller: one event (offset, tick, yaw) per input
// transaction, each passing through capture, wheel-sum multiply, spacing
// multiply and state commit before its one or two result transactions are shown;
// the next event is taken once the last result transaction has been accepted.
// Depends on irdac_pkg, irdac_if, irdac_ctrl, irdac_datapath.
`timescale 1ns / 1ps
module ir_dock_alignment_controller
  import irdac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  irdac_in_if.sink    in_ch,
  irdac_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  irdac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  irdac_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_ch.op),
    .in_ir     (in_ch.ir_value),
    .in_yaw    (in_ch.yaw_angle),
    .cmd       (cmd),
    .sts       (sts),
    .o_channel (out_ch.channel),
    .o_lin     (out_ch.lin_vel),
    .o_ang     (out_ch.ang_vel),
    .o_mode    (out_ch.mode),
    .o_failed  (out_ch.failed),
    .o_last    (out_ch.last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while results pending");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid ##1 !out_ch.valid ##1 !out_ch.valid
      ##1 out_ch.valid)
    else $error("result timing broken");

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.failed) |=> !out_ch.valid || out_ch.failed)
    else $error("failed flag dropped");

endmodule

@@ rtl/irdac_datapath.sv @@
// Datapath: configuration, alignment state, wheel mixing multipliers, results.
// Depends on irdac_pkg.
`timescale 1ns / 1ps
module irdac_datapath
  import irdac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [1:0]         in_op,
  input  logic signed [17:0] in_ir,
  input  logic [15:0]        in_yaw,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic [1:0]         o_channel,
  output logic signed [15:0] o_lin,
  output logic signed [15:0] o_ang,
  output logic [1:0]         o_mode,
  output logic               o_failed,
  output logic               o_last
);

  logic signed [15:0] fms_r, frs_r;
  logic [14:0] hs_r, ls_r, cs_r, swa_r;
  logic [15:0] iws_r;
  logic [7:0]  fmt_r;

  logic [1:0]         op_r;
  logic signed [17:0] x_r;
  logic [15:0]        yaw_r;
  logic [17:0]        a_r;
  logic [32:0]        m1_r;
  logic signed [33:0] ds_r;
  logic signed [50:0] prod_r;

  mode_t              mode_r, mode_nxt;
  logic [7:0]         fixt_r, fixt_nxt, sil_r, sil_nxt;
  logic signed [17:0] prev_r, prev_nxt, turned_r, turned_nxt;
  logic [15:0]        head_r, head_nxt, base_r, base_nxt;
  logic               act_r, act_nxt, wid_r, wid_nxt, dir_r, dir_nxt, fail_r, fail_nxt;
  res_t               res0_r, res0_nxt, res1_r, res1_nxt;
  logic               two_r, two_nxt;

  logic [17:0]        a_c;
  logic signed [33:0] m2_c;
  logic signed [33:0] linv_c;
  logic signed [17:0] linr_c;
  logic signed [23:0] angr_c;
  logic signed [15:0] lin_s, ang_s, rate_c;
  logic signed [15:0] delta_c;
  logic signed [18:0] t_c, mag_c;
  logic signed [17:0] t_sat;
  logic [15:0]        limit_c;
  logic               swing_c, fix_c;
  res_t               sw_res, fx_res;

  assign a_c = in_ir[17] ? 18'(-in_ir) : 18'(in_ir);
  assign m2_c = 34'($signed({1'b0, a_r[16:0]})) *
                (34'($signed({1'b0, hs_r})) - 34'($signed({1'b0, ls_r})));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fms_r <= 16'sd410;
      frs_r <= 16'sd819;
      hs_r  <= 15'd2048;
      ls_r  <= 15'd1024;
      cs_r  <= 15'd1024;
      iws_r <= 16'd12288;
      swa_r <= 15'd5461;
      fmt_r <= 8'd17;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIX_MOVE_SPEED:    fms_r <= cfg_wdata;
        CFG_FIX_ROTATE_SPEED:  frs_r <= cfg_wdata;
        CFG_HIGH_SPEED:        hs_r  <= cfg_wdata[14:0];
        CFG_LOW_SPEED:         ls_r  <= cfg_wdata[14:0];
        CFG_CENTER_SPEED:      cs_r  <= cfg_wdata[14:0];
        CFG_INV_WHEEL_SPACING: iws_r <= cfg_wdata;
        CFG_SWING_ANGLE:       swa_r <= cfg_wdata[14:0];
        CFG_FIX_MOVE_TICKS:    fmt_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      x_r   <= in_ir;
      yaw_r <= in_yaw;
      a_r   <= a_c;
    end
    if (cmd.mul1) begin
      m1_r <= 33'(a_r[16:0]) * (33'(hs_r) + 33'(ls_r));
      ds_r <= x_r[17] ? -m2_c : m2_c;
    end
    if (cmd.mul2) begin
      prod_r <= ds_r * $signed({1'b0, iws_r});
    end
  end

  always_comb begin
    linv_c = -$signed({1'b0, m1_r});
    linr_c = 18'((linv_c + 34'sd32768) >>> 16);
    angr_c = 24'((prod_r + 51'sd67108864) >>> 27);
    lin_s  = (linr_c > 18'sd32767) ? 16'sh7fff :
             (linr_c < -18'sd32768) ? 16'sh8000 : linr_c[15:0];
    ang_s  = (angr_c > 24'sd32767) ? 16'sh7fff :
             (angr_c < -24'sd32768) ? 16'sh8000 : angr_c[15:0];
  end

  always_comb begin
    mode_nxt   = mode_r;
    fixt_nxt   = fixt_r;
    sil_nxt    = sil_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    base_nxt   = base_r;
    turned_nxt = turned_r;
    act_nxt    = act_r;
    wid_nxt    = wid_r;
    dir_nxt    = dir_r;
    fail_nxt   = fail_r;
    res0_nxt   = '{CH_NONE, 16'sd0, 16'sd0};
    res1_nxt   = '{CH_NONE, 16'sd0, 16'sd0};
    two_nxt    = 1'b0;
    delta_c    = '0;
    t_c        = '0;
    t_sat      = '0;
    mag_c      = '0;
    limit_c    = '0;
    rate_c     = '0;
    swing_c    = 1'b0;
    fix_c      = 1'b0;
    sw_res     = '{CH_NONE, 16'sd0, 16'sd0};
    fx_res     = '{CH_NONE, 16'sd0, 16'sd0};
    unique case (op_t'(op_r))
      OP_OFFSET: begin
        sil_nxt = '0;
        act_nxt = 1'b0;
        wid_nxt = 1'b0;
        if (x_r >= -CENTRE_LIMIT && x_r <= CENTRE_LIMIT && mode_r == M_UNFIX) begin
          mode_nxt = M_FIXING;
          fixt_nxt = '0;
        end
        if (mode_nxt == M_ROTATE) begin
          if (x_r == 18'sd0 || (prev_r != 18'sd0 && (x_r[17] != prev_r[17]))) begin
            mode_nxt = M_FIXED;
          end else begin
            prev_nxt = x_r;
            res0_nxt = '{CH_DOCK, 16'sd0, x_r[17] ? neg_sat16(frs_r) : frs_r};
          end
        end else begin
          prev_nxt = x_r;
          if (a_r > UNIT_OFFSET) begin
            res0_nxt = '{CH_DRIVE, 16'sd0, 16'sd0};
          end else if (x_r == 18'sd0) begin
            res0_nxt = '{CH_DRIVE, -$signed({1'b0, cs_r}), 16'sd0};
          end else begin
            res0_nxt = '{CH_DRIVE, lin_s, ang_s};
          end
        end
      end
      OP_TICK: begin
        if (!fail_r) begin
          sil_nxt = (sil_r == 8'd255) ? sil_r : sil_r + 8'd1;
          swing_c = (sil_nxt >= 8'(NO_DATA_TICKS));
          if (swing_c) begin
            if (!act_r) begin
              act_nxt    = 1'b1;
              turned_nxt = '0;
              wid_nxt    = 1'b0;
              base_nxt   = head_r;
              dir_nxt    = prev_r[17];
            end
            delta_c = $signed(head_r - base_nxt);
            t_c = 19'(turned_nxt) + 19'(delta_c);
            t_sat = (t_c > 19'sd131071) ? 18'sh1ffff :
                    (t_c < -19'sd131072) ? 18'sh20000 : t_c[17:0];
            turned_nxt = t_sat;
            base_nxt = head_r;
            limit_c = wid_nxt ? {swa_r, 1'b0} : {1'b0, swa_r};
            mag_c = t_sat[17] ? -19'(t_sat) : 19'(t_sat);
            if (mag_c >= $signed({3'b0, limit_c})) begin
              if (!wid_nxt) begin
                wid_nxt    = 1'b1;
                dir_nxt    = ~dir_nxt;
                turned_nxt = '0;
              end else begin
                fail_nxt = 1'b1;
              end
            end
            rate_c = dir_nxt ? neg_sat16(frs_r) : frs_r;
            sw_res = '{CH_DOCK, 16'sd0, rate_c};
          end
          fix_c = (mode_r == M_FIXING);
          if (fix_c) begin
            fx_res = '{CH_DOCK, fms_r, 16'sd0};
            fixt_nxt = (fixt_r == 8'd255) ? fixt_r : fixt_r + 8'd1;
            if (fixt_nxt >= fmt_r) mode_nxt = M_ROTATE;
          end
          priority if (swing_c && fix_c) begin
            res0_nxt = sw_res;
            res1_nxt = fx_res;
            two_nxt  = 1'b1;
          end else if (swing_c) begin
            res0_nxt = sw_res;
          end else if (fix_c) begin
            res0_nxt = fx_res;
          end else begin
            res0_nxt = '{CH_NONE, 16'sd0, 16'sd0};
          end
        end
      end
      OP_YAW: head_nxt = yaw_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_UNFIX;
      fixt_r   <= '0;
      sil_r    <= '0;
      prev_r   <= '0;
      head_r   <= '0;
      base_r   <= '0;
      turned_r <= '0;
      act_r    <= 1'b0;
      wid_r    <= 1'b0;
      dir_r    <= 1'b0;
      fail_r   <= 1'b0;
      two_r    <= 1'b0;
    end else if (cmd.commit) begin
      mode_r   <= mode_nxt;
      fixt_r   <= fixt_nxt;
      sil_r    <= sil_nxt;
      prev_r   <= prev_nxt;
      head_r   <= head_nxt;
      base_r   <= base_nxt;
      turned_r <= turned_nxt;
      act_r    <= act_nxt;
      wid_r    <= wid_nxt;
      dir_r    <= dir_nxt;
      fail_r   <= fail_nxt;
      two_r    <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  assign sts.two   = two_r;
  assign o_channel = cmd.sel ? res1_r.channel : res0_r.channel;
  assign o_lin     = cmd.sel ? res1_r.lin_vel : res0_r.lin_vel;
  assign o_ang     = cmd.sel ? res1_r.ang_vel : res0_r.ang_vel;
  assign o_mode    = mode_r;
  assign o_failed  = fail_r;
  assign o_last    = cmd.sel | ~two_r;

endmodule

@@ rtl/irdac_ctrl.sv @@
// Controller: sequences load, two multiply steps, commit and result delivery.
// Depends on irdac_pkg.
`timescale 1ns / 1ps
module irdac_ctrl
  import irdac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMMIT, S_OUT0, S_OUT1
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_MUL1;
        S_MUL1:   state_r <= S_MUL2;
        S_MUL2:   state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_OUT0;
        S_OUT0:   if (out_ready) state_r <= sts.two ? S_OUT1 : S_IDLE;
        S_OUT1:   if (out_ready) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign cmd.load   = in_ready & in_valid;
  assign cmd.mul1   = (state_r == S_MUL1);
  assign cmd.mul2   = (state_r == S_MUL2);
  assign cmd.commit = (state_r == S_COMMIT);
  assign cmd.sel    = (state_r == S_OUT1);

endmodule

@@ sim/tb_ir_dock_alignment_controller.sv @@
// Self-checking testbench for ir_dock_alignment_controller: directed and random
// events through valid/ready channels, checked against an in-bench predictor.
// Depends on irdac_pkg, irdac_if and the controller RTL.
`timescale 1ns / 1ps
module tb_ir_dock_alignment_controller;
  import irdac_pkg::*;

  typedef struct {
    chan_t              channel;
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
    mode_t              mode;
    logic               failed;
    logic               last;
  } dock_cmd_t;

  class dock_scoreboard;
    logic signed [15:0] move_spd, rot_spd;
    longint hi_spd, lo_spd, ctr_spd, inv_spacing, swing_lim, move_ticks;
    mode_t  mode;
    int     fix_t, silent, prev, turned;
    logic [15:0] hdg, base_yaw;
    bit     active, widened, neg_dir, failed;
    dock_cmd_t cmd_q[$];
    dock_cmd_t batch[$];
    int     errors;

    function new();
      move_spd = 410; rot_spd = 819; hi_spd = 2048; lo_spd = 1024; ctr_spd = 1024;
      inv_spacing = 12288; swing_lim = 5461; move_ticks = 17;
      mode = M_UNFIX; fix_t = 0; silent = 0; prev = 0; turned = 0;
      hdg = 0; base_yaw = 0; active = 0; widened = 0; neg_dir = 0; failed = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_FIX_MOVE_SPEED:    move_spd = v;
        CFG_FIX_ROTATE_SPEED:  rot_spd = v;
        CFG_HIGH_SPEED:        hi_spd = v[14:0];
        CFG_LOW_SPEED:         lo_spd = v[14:0];
        CFG_CENTER_SPEED:      ctr_spd = v[14:0];
        CFG_INV_WHEEL_SPACING: inv_spacing = v;
        CFG_SWING_ANGLE:       swing_lim = v[14:0];
        CFG_FIX_MOVE_TICKS:    move_ticks = v[7:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    function longint round_q(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function void add(chan_t ch, longint lin, longint ang);
      dock_cmd_t r;
      r.channel = ch; r.lin_vel = sat16(lin); r.ang_vel = sat16(ang);
      r.mode = M_UNFIX; r.failed = 0; r.last = 0;
      batch.push_back(r);
    endfunction

    function void offset_event(int x);
      longint a, l, r;
      silent = 0; active = 0; widened = 0;
      if (x >= -327 && x <= 327 && mode == M_UNFIX) begin
        mode = M_FIXING;
        fix_t = 0;
      end
      if (mode == M_ROTATE) begin
        if (x == 0 || (prev != 0 && ((x < 0) != (prev < 0)))) begin
          mode = M_FIXED;
          add(CH_NONE, 0, 0);
        end else begin
          prev = x;
          add(CH_DOCK, 0, x > 0 ? longint'(rot_spd) : -longint'(rot_spd));
        end
        return;
      end
      prev = x;
      a = x < 0 ? -x : x;
      if (a > 32768) begin
        add(CH_DRIVE, 0, 0);
        return;
      end
      if (x < 0) begin
        l = a * hi_spd; r = a * lo_spd;
      end else if (x > 0) begin
        l = a * lo_spd; r = a * hi_spd;
      end else begin
        l = ctr_spd <<< 15; r = l;
      end
      add(CH_DRIVE, round_q(-(l + r), 16), round_q((r - l) * inv_spacing, 27));
    endfunction

    function void swing_step();
      logic signed [15:0] delta;
      longint t, lim;
      if (!active) begin
        active = 1; turned = 0; widened = 0; base_yaw = hdg; neg_dir = prev < 0;
      end
      delta = hdg - base_yaw;
      t = longint'(turned) + delta;
      if (t > 131071) t = 131071;
      if (t < -131072) t = -131072;
      turned = int'(t);
      base_yaw = hdg;
      lim = widened ? 2 * swing_lim : swing_lim;
      if ((t < 0 ? -t : t) >= lim) begin
        if (!widened) begin
          widened = 1; neg_dir = !neg_dir; turned = 0;
        end else begin
          failed = 1;
        end
      end
    endfunction

    function void tick_event();
      if (failed) return;
      if (silent < 255) silent++;
      if (silent >= NO_DATA_TICKS) begin
        swing_step();
        add(CH_DOCK, 0, neg_dir ? -longint'(rot_spd) : longint'(rot_spd));
      end
      if (mode == M_FIXING) begin
        add(CH_DOCK, move_spd, 0);
        if (fix_t < 255) fix_t++;
        if (fix_t >= move_ticks) mode = M_ROTATE;
      end
    endfunction

    function void note_input(op_t op, logic signed [17:0] ir, logic [15:0] yaw);
      batch.delete();
      case (op)
        OP_OFFSET: offset_event(int'(ir));
        OP_TICK:   tick_event();
        OP_YAW:    hdg = yaw;
        default: ;
      endcase
      if (batch.size() == 0) add(CH_NONE, 0, 0);
      foreach (batch[i]) begin
        batch[i].mode = mode;
        batch[i].failed = failed;
        batch[i].last = (i == batch.size() - 1);
        cmd_q.push_back(batch[i]);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(dock_cmd_t got);
      dock_cmd_t e;
      if (cmd_q.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      e = cmd_q.pop_front();
      if (got.channel !== e.channel)
        report($sformatf("channel %0d, expected %0d", got.channel, e.channel));
      if (got.lin_vel !== e.lin_vel)
        report($sformatf("lin_vel %0d, expected %0d", got.lin_vel, e.lin_vel));
      if (got.ang_vel !== e.ang_vel)
        report($sformatf("ang_vel %0d, expected %0d", got.ang_vel, e.ang_vel));
      if (got.mode !== e.mode)
        report($sformatf("mode %0d, expected %0d", got.mode, e.mode));
      if (got.failed !== e.failed)
        report($sformatf("failed %0b, expected %0b", got.failed, e.failed));
      if (got.last !== e.last)
        report($sformatf("last %0b, expected %0b", got.last, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  irdac_in_if  in_bus();
  irdac_out_if out_bus();

  ir_dock_alignment_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_ch(in_bus), .out_ch(out_bus)
  );

  dock_scoreboard sb = new();
  bit          calm;
  logic [15:0] yaw_now;
  int          result_count;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("ir_dock_alignment_controller verification failed");
    $finish;
  end

  function int draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task send_item(op_t op, logic signed [17:0] ir, logic [15:0] yaw);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.op <= op;
    in_bus.ir_value <= ir;
    in_bus.yaw_angle <= yaw;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(op, ir, yaw);
  endtask

  task settle();
    in_bus.valid <= 1'b0;
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task load_config(logic [15:0] mv, logic [15:0] rot, logic [15:0] hi, logic [15:0] lo,
                   logic [15:0] ctr, logic [15:0] inv, logic [15:0] sw, logic [15:0] tk);
    settle();
    write_reg(CFG_FIX_MOVE_SPEED, mv);
    write_reg(CFG_FIX_ROTATE_SPEED, rot);
    write_reg(CFG_HIGH_SPEED, hi);
    write_reg(CFG_LOW_SPEED, lo);
    write_reg(CFG_CENTER_SPEED, ctr);
    write_reg(CFG_INV_WHEEL_SPACING, inv);
    write_reg(CFG_SWING_ANGLE, sw);
    write_reg(CFG_FIX_MOVE_TICKS, tk);
    cfg_we <= 1'b0;
  endtask

  task random_config();
    load_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)),
                16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                16'($urandom), 16'($urandom_range(2000, 32767)),
                16'($urandom_range(0, 40)));
  endtask

  task silent_sweep(int n);
    repeat (n) begin
      yaw_now = yaw_now + 16'($urandom_range(0, 6000)) - 16'd3000;
      send_item(OP_YAW, 18'($urandom), yaw_now);
      send_item(OP_TICK, 18'($urandom), 16'($urandom));
    end
  endtask

  task random_item();
    int r, s;
    logic signed [17:0] ir;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 9);
    if (s < 3) ir = 18'($urandom_range(0, 654) - 327);
    else if (s == 3) ir = (($urandom & 1) ? 18'sh1ffff : 18'sh20000);
    else if (s == 4) ir = 18'($urandom);
    else if (s == 5) ir = (($urandom & 1) ? 18'sd32769 : -18'sd32769);
    else ir = 18'($urandom_range(0, 65536) - 32768);
    if (r < 40) begin
      send_item(OP_OFFSET, ir, 16'($urandom));
    end else if (r < 80) begin
      send_item(OP_TICK, ir, 16'($urandom));
    end else if (r < 94) begin
      if (s == 0) yaw_now = 16'($urandom);
      else yaw_now = yaw_now + 16'($urandom_range(0, 4000)) - 16'd2000;
      send_item(OP_YAW, ir, yaw_now);
    end else if (r < 97) begin
      send_item(OP_NONE, ir, 16'($urandom));
    end else begin
      silent_sweep($urandom_range(4, 9));
    end
  endtask

  task random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      random_item();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.op <= OP_NONE;
    in_bus.ir_value <= '0;
    in_bus.yaw_angle <= '0;
    out_bus.ready <= 1'b0;
    calm = 0;
    yaw_now = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_config(16'd410, 16'd819, 16'd2048, 16'd1024, 16'd1024, 16'd12288, 16'd5461, 16'd3);
    send_item(OP_YAW, 18'sd0, 16'd0);
    send_item(OP_OFFSET, 18'sh1ffff, 16'hffff);
    send_item(OP_OFFSET, 18'sh20000, 16'd0);
    send_item(OP_OFFSET, 18'sd32768, 16'd0);
    send_item(OP_OFFSET, -18'sd32768, 16'd0);
    send_item(OP_OFFSET, 18'sd32769, 16'd0);
    send_item(OP_OFFSET, 18'sd1000, 16'd0);
    send_item(OP_OFFSET, -18'sd1000, 16'd0);
    send_item(OP_NONE, 18'sh15555, 16'haaaa);
    send_item(OP_OFFSET, 18'sd327, 16'd0);
    repeat (3) send_item(OP_TICK, 18'sd0, 16'd0);
    send_item(OP_OFFSET, 18'sd400, 16'd0);
    send_item(OP_OFFSET, 18'sd200, 16'd0);
    send_item(OP_OFFSET, -18'sd50, 16'd0);
    send_item(OP_OFFSET, 18'sd0, 16'd0);
    send_item(OP_OFFSET, -18'sd327, 16'd0);
    silent_sweep(8);

    random_config();
    random_run(90);
    load_config(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'h7fff, 16'hff);
    random_run(90);
    load_config(16'h7fff, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd20000, 16'd0);
    random_run(70);
    random_config();
    random_run(90);
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_run(60);
    silent_sweep(10);
    random_run(30);

    settle();
    if (sb.errors == 0)
      $display("ir_dock_alignment_controller verification clean");
    else
      $display("ir_dock_alignment_controller verification failed");
    $finish;
  end

  initial begin
    int stall;
    dock_cmd_t got;
    result_count = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got.channel = chan_t'(out_bus.channel);
      got.lin_vel = out_bus.lin_vel;
      got.ang_vel = out_bus.ang_vel;
      got.mode = mode_t'(out_bus.mode);
      got.failed = out_bus.failed;
      got.last = out_bus.last;
      sb.check_result(got);
      result_count++;
      // long back-pressure stretch; sender keeps offering
      if (result_count == 200) begin
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end
endmodule

@@ sim.f @@
rtl/irdac_pkg.sv
rtl/irdac_if.sv
rtl/irdac_datapath.sv
rtl/irdac_ctrl.sv
rtl/ir_dock_alignment_controller.sv
sim/tb_ir_dock_alignment_controller.sv
